[src/capacitive_pressure_to_loop_current_defines.svh]
// assertion macros shared by the pressure to loop current block
`ifndef CAPACITIVE_PRESSURE_TO_LOOP_CURRENT_DEFINES_SVH
`define CAPACITIVE_PRESSURE_TO_LOOP_CURRENT_DEFINES_SVH

// same-cycle implication, checked out of reset
`define CPL_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("implication check failed");

// next-cycle implication, checked out of reset
`define CPL_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

[src/cpl_pkg.sv]
// shared types, constants and helpers for the pressure to loop current block
package cpl_pkg;

    localparam int W_P     = 32;
    localparam int W_T     = 16;
    localparam int W_UA    = 15;
    localparam int W_CFG   = 32;
    localparam int W_IDX   = 3;
    localparam int W_DAMP  = 16;

    localparam int MUL_AW  = 48;
    localparam int MUL_BW  = 34;
    localparam int DIV_NW  = 49;
    localparam int DIV_DW  = 33;

    localparam int SAT_LOW_UA_DEF   = 3800;
    localparam int SAT_HIGH_UA_DEF  = 20500;
    localparam int ALARM_LOW_UA_DEF = 3600;
    localparam int TICK_MS_DEF      = 100;

    localparam int UA_ZERO = 4000;
    localparam int UA_SPAN = 16000;
    localparam int FRAC_LIMIT = 1 << 29;

    localparam logic [W_IDX-1:0] REG_CAP_ZERO   = 3'd0;
    localparam logic [W_IDX-1:0] REG_CAP_FULL   = 3'd1;
    localparam logic [W_IDX-1:0] REG_PRESS_LOW  = 3'd2;
    localparam logic [W_IDX-1:0] REG_PRESS_HIGH = 3'd3;
    localparam logic [W_IDX-1:0] REG_TEMP_REF   = 3'd4;
    localparam logic [W_IDX-1:0] REG_ZERO_TC    = 3'd5;
    localparam logic [W_IDX-1:0] REG_SPAN_TC    = 3'd6;
    localparam logic [W_IDX-1:0] REG_DAMPING    = 3'd7;

    typedef enum logic [2:0] {
        PH_FRAC,
        PH_LIN,
        PH_COEF,
        PH_TEMP,
        PH_FILT,
        PH_CUR
    } t_phase;

    typedef struct packed {
        logic   load;
        logic   start;
        logic   finish;
        t_phase phase;
    } t_cmd;

    typedef struct packed {
        logic sample;
        logic span_zero;
        logic damp_zero;
        logic cur_direct;
        logic unit_done;
        logic out_full;
    } t_stat;

    function automatic logic signed [W_P-1:0] sat32(input logic signed [63:0] v);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        hi = 64'sh0000_0000_7FFF_FFFF;
        lo = -64'sh0000_0000_8000_0000;
        if (v > hi) begin
            return hi[W_P-1:0];
        end else if (v < lo) begin
            return lo[W_P-1:0];
        end
        return v[W_P-1:0];
    endfunction

endpackage

[src/capacitive_pressure_to_loop_current.sv]
// top level of the capacitive pressure to 4-20 ma loop current block
//
// input channel: i_in_valid / o_in_ready, one transaction per sensor tick
// carrying delta_cap, temperature and the sample / fault / loop flags.
// output channel: o_out_valid / i_out_ready, one result per input transaction.
// config port: i_cfg_we writes i_cfg_data into register i_cfg_idx, no wait.
// a sample transaction runs through one shared shift-add multiplier and one
// restoring divider: calibration divide (49 iterations), three multiplies
// (34 iterations each), filter divide and current divide (49 iterations
// each). the filter divide is skipped when damping is zero and the current
// divide when the current saturates or the pressure span is zero. a zero
// capacitance span skips the calibration divide and the multiplies; fault
// or idle ticks skip all arithmetic.
// one transaction is in flight at a time; o_in_ready is high only while
// the sequencer is idle.
// the result sits in an output register, so the next transaction is taken
// while it waits; if the receiver still stalls at the end of the next one,
// the sequencer holds there until the register drains.
// reset (synchronous, active low) loads the default calibration and
// clears the damping filter state and the output valid.
module capacitive_pressure_to_loop_current #(
    parameter int SAT_LOW_UA   = cpl_pkg::SAT_LOW_UA_DEF,
    parameter int SAT_HIGH_UA  = cpl_pkg::SAT_HIGH_UA_DEF,
    parameter int ALARM_LOW_UA = cpl_pkg::ALARM_LOW_UA_DEF,
    parameter int TICK_MS      = cpl_pkg::TICK_MS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration writes
    input  logic                           i_cfg_we,
    input  logic [cpl_pkg::W_IDX-1:0]      i_cfg_idx,
    input  logic [cpl_pkg::W_CFG-1:0]      i_cfg_data,
    // input transaction
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic signed [cpl_pkg::W_P-1:0] i_delta_cap,
    input  logic signed [cpl_pkg::W_T-1:0] i_temperature,
    input  logic                           i_has_sample,
    input  logic                           i_sensor_fault,
    input  logic                           i_loop_enabled,
    input  logic                           i_drive_allowed,
    // result transaction
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic signed [cpl_pkg::W_P-1:0] o_pressure_instant,
    output logic signed [cpl_pkg::W_P-1:0] o_pressure_damped,
    output logic [cpl_pkg::W_UA-1:0]       o_current_ua,
    output logic                           o_current_write,
    output logic                           o_alarm_low
);
    cpl_pkg::t_cmd  cmd;
    cpl_pkg::t_stat stat;

    // sequencer
    cpl_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (stat),
        .o_in_ready  (o_in_ready),
        .o_cmd       (cmd)
    );

    // arithmetic, config registers, filter state and output register
    cpl_dp #(
        .SAT_LOW_UA   (SAT_LOW_UA),
        .SAT_HIGH_UA  (SAT_HIGH_UA),
        .ALARM_LOW_UA (ALARM_LOW_UA),
        .TICK_MS      (TICK_MS)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_idx          (i_cfg_idx),
        .i_cfg_data         (i_cfg_data),
        .i_delta_cap        (i_delta_cap),
        .i_temperature      (i_temperature),
        .i_has_sample       (i_has_sample),
        .i_sensor_fault     (i_sensor_fault),
        .i_loop_enabled     (i_loop_enabled),
        .i_drive_allowed    (i_drive_allowed),
        .i_out_ready        (i_out_ready),
        .i_cmd              (cmd),
        .o_stat             (stat),
        .o_out_valid        (o_out_valid),
        .o_pressure_instant (o_pressure_instant),
        .o_pressure_damped  (o_pressure_damped),
        .o_current_ua       (o_current_ua),
        .o_current_write    (o_current_write),
        .o_alarm_low        (o_alarm_low)
    );

endmodule

[src/cpl_mul.sv]
// shift-add signed multiplier, one multiplier bit per cycle
module cpl_mul #(
    parameter int AW = cpl_pkg::MUL_AW,
    parameter int BW = cpl_pkg::MUL_BW
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic signed [AW-1:0]    i_a,
    input  logic signed [BW-1:0]    i_b,
    output logic                    o_done,
    output logic signed [AW+BW-1:0] o_prod
);
    localparam int PW = AW + BW;
    localparam int CW = $clog2(BW + 1);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [PW-1:0] r_mcand;
    logic [BW-1:0] r_mplier;
    logic [PW-1:0] r_acc;
    logic          r_neg;
    logic [AW-1:0] a_mag;
    logic [BW-1:0] b_mag;

    assign a_mag = i_a[AW-1] ? AW'(-i_a) : AW'(i_a);
    assign b_mag = i_b[BW-1] ? BW'(-i_b) : BW'(i_b);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CW'(1);
                if (r_cnt == CW'(BW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_mcand  <= PW'(a_mag);
            r_mplier <= b_mag;
            r_acc    <= '0;
            r_neg    <= i_a[AW-1] ^ i_b[BW-1];
        end else if (r_busy) begin
            if (r_mplier[0]) begin
                r_acc <= r_acc + r_mcand;
            end
            r_mcand  <= r_mcand << 1;
            r_mplier <= r_mplier >> 1;
        end
    end

    assign o_done = r_done;
    assign o_prod = r_neg ? -$signed(r_acc) : $signed(r_acc);

endmodule

[src/cpl_div.sv]
// restoring unsigned divider, one quotient bit per cycle
module cpl_div #(
    parameter int NW = cpl_pkg::DIV_NW,
    parameter int DW = cpl_pkg::DIV_DW
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic          o_done,
    output logic [NW-1:0] o_quo
);
    localparam int CW = $clog2(NW + 1);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_den;
    logic [NW-1:0] r_quo;
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          fits;

    assign trial = {r_rem, r_quo[NW-1]};
    assign diff  = trial - {1'b0, r_den};
    assign fits  = trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CW'(1);
                if (r_cnt == CW'(NW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_den <= i_den;
            r_quo <= i_num;
        end else if (r_busy) begin
            r_rem <= fits ? diff[DW-1:0] : trial[DW-1:0];
            r_quo <= {r_quo[NW-2:0], fits};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

[src/cpl_dp.sv]
// datapath: registers, calibration arithmetic, filter, current mapping
module cpl_dp #(
    parameter int SAT_LOW_UA   = cpl_pkg::SAT_LOW_UA_DEF,
    parameter int SAT_HIGH_UA  = cpl_pkg::SAT_HIGH_UA_DEF,
    parameter int ALARM_LOW_UA = cpl_pkg::ALARM_LOW_UA_DEF,
    parameter int TICK_MS      = cpl_pkg::TICK_MS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [cpl_pkg::W_IDX-1:0]          i_cfg_idx,
    input  logic [cpl_pkg::W_CFG-1:0]          i_cfg_data,
    input  logic signed [cpl_pkg::W_P-1:0]     i_delta_cap,
    input  logic signed [cpl_pkg::W_T-1:0]     i_temperature,
    input  logic                               i_has_sample,
    input  logic                               i_sensor_fault,
    input  logic                               i_loop_enabled,
    input  logic                               i_drive_allowed,
    input  logic                               i_out_ready,
    input  cpl_pkg::t_cmd                      i_cmd,
    output cpl_pkg::t_stat                     o_stat,
    output logic                               o_out_valid,
    output logic signed [cpl_pkg::W_P-1:0]     o_pressure_instant,
    output logic signed [cpl_pkg::W_P-1:0]     o_pressure_damped,
    output logic [cpl_pkg::W_UA-1:0]           o_current_ua,
    output logic                               o_current_write,
    output logic                               o_alarm_low
);
    localparam int P = cpl_pkg::W_P;
    localparam int AW = cpl_pkg::MUL_AW;
    localparam int BW = cpl_pkg::MUL_BW;
    localparam int NW = cpl_pkg::DIV_NW;
    localparam int DW = cpl_pkg::DIV_DW;
    localparam int UW = cpl_pkg::W_UA;

    // configuration
    logic signed [P-1:0]              r_cap_zero, r_cap_full, r_press_low, r_press_high;
    logic signed [cpl_pkg::W_T-1:0]   r_temp_ref;
    logic signed [P-1:0]              r_zero_tc, r_span_tc;
    logic [cpl_pkg::W_DAMP-1:0]       r_damp;

    // captured transaction
    logic signed [P-1:0]              r_dc;
    logic signed [cpl_pkg::W_T-1:0]   r_temp;
    logic                             r_sample, r_fault, r_en, r_allow;

    // working values
    logic signed [30:0]               r_frac;
    logic signed [47:0]               r_plin;
    logic signed [46:0]               r_coef;
    logic signed [P-1:0]              r_pinst;
    logic signed [P-1:0]              r_y;
    logic [UW-1:0]                    r_ua;
    logic                             r_out_valid;

    logic signed [32:0]      span, dcd, pdiff, fdiff;
    logic signed [48:0]      num;
    logic [NW-1:0]           num_mag;
    logic [DW-1:0]           span_mag;
    logic                    frac_neg;
    logic signed [16:0]      dtemp;
    logic signed [AW-1:0]    mul_a;
    logic signed [BW-1:0]    mul_b;
    logic                    mul_start, mul_done;
    logic signed [AW+BW-1:0] prod;
    logic [NW-1:0]           div_num, quo;
    logic [DW-1:0]           div_den;
    logic                    div_start, div_done;
    logic [29:0]             frac_sat;
    logic [DW-1:0]           fdiff_mag;
    logic signed [33:0]      fstep, ysum, s34, d34, sn, dn;
    logic signed [56:0]      ptmp;
    logic                    span_zero, damp_zero, cur_direct;
    logic [UW-1:0]           ua_direct;

    assign span      = 33'(r_cap_full) - 33'(r_cap_zero);
    assign span_zero = (r_cap_full == r_cap_zero);
    assign damp_zero = (r_damp == '0);
    assign dcd       = 33'(r_dc) - 33'(r_cap_zero);
    assign num       = {dcd, 16'b0};
    assign num_mag   = num[48] ? NW'(-num) : NW'(num);
    assign span_mag  = span[32] ? DW'(-span) : DW'(span);
    assign frac_neg  = num[48] ^ span[32];
    assign pdiff     = 33'(r_press_high) - 33'(r_press_low);
    assign dtemp     = 17'(r_temp) - 17'(r_temp_ref);
    assign fdiff     = 33'(r_pinst) - 33'(r_y);
    assign fdiff_mag = fdiff[32] ? DW'(-fdiff) : DW'(fdiff);

    // current mapping on the filtered value, direction follows the span sign
    assign s34 = 34'(pdiff);
    assign d34 = 34'(r_y) - 34'(r_press_low);
    assign sn  = s34[33] ? -s34 : s34;
    assign dn  = s34[33] ? -d34 : d34;
    assign cur_direct = (s34 == '0) || dn[33] || (dn > sn);

    always_comb begin
        if (s34 == '0) begin
            ua_direct = UW'(cpl_pkg::UA_ZERO);
        end else if (dn[33]) begin
            ua_direct = UW'(SAT_LOW_UA);
        end else begin
            ua_direct = UW'(SAT_HIGH_UA);
        end
    end

    // operand selection
    always_comb begin
        unique case (i_cmd.phase)
            cpl_pkg::PH_LIN: begin
                mul_a = AW'(pdiff);
                mul_b = BW'(r_frac);
            end
            cpl_pkg::PH_COEF: begin
                mul_a = AW'(r_span_tc);
                mul_b = BW'(r_frac);
            end
            default: begin
                mul_a = AW'(r_coef);
                mul_b = BW'(dtemp);
            end
        endcase
    end

    always_comb begin
        unique case (i_cmd.phase)
            cpl_pkg::PH_FILT: begin
                div_num = NW'(fdiff_mag) * NW'(TICK_MS);
                div_den = DW'(r_damp) + DW'(TICK_MS);
            end
            cpl_pkg::PH_CUR: begin
                div_num = NW'(dn[32:0]) * NW'(cpl_pkg::UA_SPAN);
                div_den = sn[DW-1:0];
            end
            default: begin
                div_num = num_mag;
                div_den = span_mag;
            end
        endcase
    end

    assign mul_start = i_cmd.start && (i_cmd.phase == cpl_pkg::PH_LIN ||
                       i_cmd.phase == cpl_pkg::PH_COEF || i_cmd.phase == cpl_pkg::PH_TEMP);
    assign div_start = i_cmd.start && (i_cmd.phase == cpl_pkg::PH_FRAC ||
                       (i_cmd.phase == cpl_pkg::PH_FILT && !damp_zero) ||
                       (i_cmd.phase == cpl_pkg::PH_CUR && !cur_direct));

    cpl_mul #(.AW(AW), .BW(BW)) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_prod  (prod)
    );

    cpl_div #(.NW(NW), .DW(DW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quo   (quo)
    );

    assign frac_sat = (quo > NW'(cpl_pkg::FRAC_LIMIT)) ? 30'(cpl_pkg::FRAC_LIMIT) : quo[29:0];
    assign fstep    = fdiff[32] ? -34'(quo[32:0]) : 34'(quo[32:0]);
    assign ysum     = 34'(r_y) + fstep;
    assign ptmp     = 57'(r_plin) - 57'(prod >>> 8);

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap_zero   <= '0;
            r_cap_full   <= '0;
            r_press_low  <= '0;
            r_press_high <= 32'sd655360;
            r_temp_ref   <= 16'sd6400;
            r_zero_tc    <= '0;
            r_span_tc    <= '0;
            r_damp       <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                cpl_pkg::REG_CAP_ZERO:   r_cap_zero   <= i_cfg_data;
                cpl_pkg::REG_CAP_FULL:   r_cap_full   <= i_cfg_data;
                cpl_pkg::REG_PRESS_LOW:  r_press_low  <= i_cfg_data;
                cpl_pkg::REG_PRESS_HIGH: r_press_high <= i_cfg_data;
                cpl_pkg::REG_TEMP_REF:   r_temp_ref   <= i_cfg_data[cpl_pkg::W_T-1:0];
                cpl_pkg::REG_ZERO_TC:    r_zero_tc    <= i_cfg_data;
                cpl_pkg::REG_SPAN_TC:    r_span_tc    <= i_cfg_data;
                cpl_pkg::REG_DAMPING:    r_damp       <= i_cfg_data[cpl_pkg::W_DAMP-1:0];
            endcase
        end
    end

    // payload and working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_dc     <= i_delta_cap;
            r_temp   <= i_temperature;
            r_sample <= i_has_sample;
            r_fault  <= i_sensor_fault;
            r_en     <= i_loop_enabled;
            r_allow  <= i_drive_allowed;
            r_pinst  <= r_press_low;
        end
        if (div_done) begin
            unique case (i_cmd.phase)
                cpl_pkg::PH_FRAC: r_frac <= frac_neg ? -31'(frac_sat) : 31'(frac_sat);
                cpl_pkg::PH_CUR:  r_ua   <= UW'(quo[13:0]) + UW'(cpl_pkg::UA_ZERO);
                default: ;
            endcase
        end
        if (mul_done) begin
            unique case (i_cmd.phase)
                cpl_pkg::PH_LIN:  r_plin  <= 48'(r_press_low) + 48'(prod >>> 16);
                cpl_pkg::PH_COEF: r_coef  <= 47'(r_zero_tc) + 47'(prod >>> 16);
                default:          r_pinst <= cpl_pkg::sat32(64'(ptmp));
            endcase
        end
        if (i_cmd.start && i_cmd.phase == cpl_pkg::PH_CUR && cur_direct) begin
            r_ua <= ua_direct;
        end
        if (i_cmd.finish) begin
            o_pressure_instant <= r_sample ? r_pinst : '0;
            o_pressure_damped  <= r_y;
            o_current_ua       <= r_sample ? r_ua :
                                  (r_fault ? UW'(ALARM_LOW_UA) : '0);
            o_current_write    <= r_sample ? (r_en && r_allow) : (r_fault && r_en);
            o_alarm_low        <= !r_sample && r_fault;
        end
    end

    // filter state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_y         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.start && i_cmd.phase == cpl_pkg::PH_FILT && damp_zero) begin
                r_y <= r_pinst;
            end else if (div_done && i_cmd.phase == cpl_pkg::PH_FILT) begin
                r_y <= cpl_pkg::sat32(64'(ysum));
            end
            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_stat.sample     = r_sample;
    assign o_stat.span_zero  = span_zero;
    assign o_stat.damp_zero  = damp_zero;
    assign o_stat.cur_direct = cur_direct;
    assign o_stat.unit_done  = mul_done || div_done;
    assign o_stat.out_full   = r_out_valid;

endmodule

[src/cpl_ctrl.sv]
// sequencer that steps the datapath through one transaction
`include "capacitive_pressure_to_loop_current_defines.svh"

module cpl_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_out_ready,
    input  cpl_pkg::t_stat i_stat,
    output logic           o_in_ready,
    output cpl_pkg::t_cmd  o_cmd
);
    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_FRAC_GO,
        S_FRAC_WAIT,
        S_LIN_GO,
        S_LIN_WAIT,
        S_COEF_GO,
        S_COEF_WAIT,
        S_TEMP_GO,
        S_TEMP_WAIT,
        S_FILT_GO,
        S_FILT_WAIT,
        S_CUR_GO,
        S_CUR_WAIT,
        S_FIN
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        o_cmd.load   = 1'b0;
        o_cmd.start  = 1'b0;
        o_cmd.finish = 1'b0;
        o_cmd.phase  = cpl_pkg::PH_FRAC;
        n_state      = r_state;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.load = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                if (!i_stat.sample) begin
                    n_state = S_FIN;
                end else if (i_stat.span_zero) begin
                    n_state = S_FILT_GO;
                end else begin
                    n_state = S_FRAC_GO;
                end
            end
            S_FRAC_GO: begin
                o_cmd.start = 1'b1;
                n_state     = S_FRAC_WAIT;
            end
            S_FRAC_WAIT: begin
                if (i_stat.unit_done) begin
                    n_state = S_LIN_GO;
                end
            end
            S_LIN_GO: begin
                o_cmd.start = 1'b1;
                o_cmd.phase = cpl_pkg::PH_LIN;
                n_state     = S_LIN_WAIT;
            end
            S_LIN_WAIT: begin
                o_cmd.phase = cpl_pkg::PH_LIN;
                if (i_stat.unit_done) begin
                    n_state = S_COEF_GO;
                end
            end
            S_COEF_GO: begin
                o_cmd.start = 1'b1;
                o_cmd.phase = cpl_pkg::PH_COEF;
                n_state     = S_COEF_WAIT;
            end
            S_COEF_WAIT: begin
                o_cmd.phase = cpl_pkg::PH_COEF;
                if (i_stat.unit_done) begin
                    n_state = S_TEMP_GO;
                end
            end
            S_TEMP_GO: begin
                o_cmd.start = 1'b1;
                o_cmd.phase = cpl_pkg::PH_TEMP;
                n_state     = S_TEMP_WAIT;
            end
            S_TEMP_WAIT: begin
                o_cmd.phase = cpl_pkg::PH_TEMP;
                if (i_stat.unit_done) begin
                    n_state = S_FILT_GO;
                end
            end
            S_FILT_GO: begin
                o_cmd.start = 1'b1;
                o_cmd.phase = cpl_pkg::PH_FILT;
                n_state     = i_stat.damp_zero ? S_CUR_GO : S_FILT_WAIT;
            end
            S_FILT_WAIT: begin
                o_cmd.phase = cpl_pkg::PH_FILT;
                if (i_stat.unit_done) begin
                    n_state = S_CUR_GO;
                end
            end
            S_CUR_GO: begin
                o_cmd.start = 1'b1;
                o_cmd.phase = cpl_pkg::PH_CUR;
                n_state     = i_stat.cur_direct ? S_FIN : S_CUR_WAIT;
            end
            S_CUR_WAIT: begin
                o_cmd.phase = cpl_pkg::PH_CUR;
                if (i_stat.unit_done) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (!i_stat.out_full || i_out_ready) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    `CPL_ASSERT_NEXT(a_load_leaves_idle, i_clk, i_rst_n, o_cmd.load, r_state != S_IDLE)
    `CPL_ASSERT_IMPL(a_no_done_in_idle, i_clk, i_rst_n, r_state == S_IDLE, !i_stat.unit_done)
    `CPL_ASSERT_NEXT(a_finish_to_idle, i_clk, i_rst_n, o_cmd.finish, r_state == S_IDLE)

endmodule
